>>> design/rfhx_pkg.sv
// shared constants, item type and hex digit decode for the rfid frame parser
package rfhx_pkg;

   localparam int STORE_DEPTH   = 16;
   localparam int POS_W         = $clog2(STORE_DEPTH);
   localparam int FRAME_END_POS = 13;
   localparam int TAG_BYTES     = 5;
   localparam int TAG_W         = 8 * TAG_BYTES;
   localparam int RSP_DATA_W    = ((TAG_W + 1 + 7) / 8) * 8;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] FRAME_STX = 8'h02;
   localparam logic [7:0] FRAME_ETX = 8'h03;

   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_STX  = 2'd1;
   localparam logic [1:0] KIND_ETX  = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] rx_byte;
   } item_type;

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         v = c[3:0];
      end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         v = c[3:0] + 4'd9;
      end
      return v;
   endfunction

endpackage

>>> design/rfid_ascii_hex_frame_parser.sv
// top level of the rfid reader ascii hex frame parser
//
// req channel: one received serial byte per beat. 0x02 starts a frame,
// 0x03 ends it, anything else is written into a 16-byte frame store.
// rsp channel: one beat per good frame end (header 0x02, end at position
// 13): tag_id with the first tag byte in the top bits, and checksum_ok
// set when the xor of the five tag bytes matches the received checksum.
// other bytes produce no beat.
//
// a result is valid once its end byte has passed through the queue and the
// output register. the back end takes one byte per cycle while no result
// waits with rsp_tready low, with a registered store update and combinational tag decode.
// a two-entry queue sits between byte intake and the back end, and the
// result sits in an output register, so intake continues while a result
// waits. while a result waits with rsp_tready low the back end holds, the
// queue fills and req_tready drops after at most two more bytes.
// reset clears the frame store, the write position, the queue and the
// output valid flag; req_tready is high right after reset.
module rfid_ascii_hex_frame_parser (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // rx_byte[7:0]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rfhx_pkg::RSP_DATA_W-1:0]      rsp_tdata   // tag_id[39:0], checksum_ok[40]
);
   import rfhx_pkg::*;

   logic     push;
   item_type push_item;
   logic     queue_full;
   logic     queue_not_empty;
   item_type head_item;
   logic     pop;

   rfhx_front u_front (
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .req_tready (req_tready),
      .push       (push),
      .push_item  (push_item)
   );

   rfhx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_item (head_item)
   );

   rfhx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_not_empty),
      .item       (head_item),
      .item_pop   (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> design/rfhx_front.sv
// front end: accepts received bytes and tags each as frame start, frame end or data
module rfhx_front (
   input  logic              req_tvalid,
   input  logic [7:0]        req_tdata,
   input  logic              queue_full,
   output logic              req_tready,
   output logic              push,
   output rfhx_pkg::item_type push_item
);
   import rfhx_pkg::*;

   always_comb begin
      push_item.rx_byte = req_tdata;
      case (req_tdata)
         FRAME_STX: push_item.kind = KIND_STX;
         FRAME_ETX: push_item.kind = KIND_ETX;
         default:   push_item.kind = KIND_DATA;
      endcase
   end

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

endmodule

>>> design/rfhx_queue.sv
// short queue of classified bytes between front and back end
module rfhx_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rfhx_pkg::item_type push_item,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output rfhx_pkg::item_type head_item
);
   import rfhx_pkg::*;

   item_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> design/rfhx_back.sv
// back end: frame store, write position, tag decode and result register
module rfhx_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  item_valid,
   input  rfhx_pkg::item_type                    item,
   output logic                                  item_pop,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [rfhx_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import rfhx_pkg::*;

   logic [7:0]            store_ff [STORE_DEPTH];
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TAG_W-1:0]      tag_ff;
   logic                  sum_ok_ff;
   logic [TAG_W-1:0]      tag_dec;
   logic [7:0]            xor_dec;
   logic [7:0]            sum_dec;
   logic                  frame_hit;

   assign item_pop = item_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      logic [7:0] b;
      tag_dec = '0;
      xor_dec = '0;
      for (int i = 0; i < TAG_BYTES; i++) begin
         b = {hex_nibble(store_ff[2*i+1]), hex_nibble(store_ff[2*i+2])};
         tag_dec = {tag_dec[TAG_W-9:0], b};
         xor_dec = xor_dec ^ b;
      end
      sum_dec = {hex_nibble(store_ff[2*TAG_BYTES+1]), hex_nibble(store_ff[2*TAG_BYTES+2])};
   end

   assign frame_hit = (item.kind == KIND_ETX) && (store_ff[0] == FRAME_STX)
                      && (pos_ff == POS_W'(FRAME_END_POS));

   always_comb begin
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (item_pop) begin
         rsp_valid_in = frame_hit;
         case (item.kind)
            KIND_STX: pos_in = POS_W'(1);
            KIND_ETX: pos_in = '0;
            default:  pos_in = (pos_ff == POS_W'(STORE_DEPTH - 1)) ? '0 : pos_ff + 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < STORE_DEPTH; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (item_pop) begin
            case (item.kind)
               KIND_STX: store_ff[0]      <= FRAME_STX;
               KIND_ETX: store_ff[pos_ff] <= FRAME_ETX;
               default:  store_ff[pos_ff] <= item.rx_byte;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop && frame_hit) begin
         tag_ff    <= tag_dec;
         sum_ok_ff <= (sum_dec == xor_dec);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - TAG_W - 1){1'b0}}, sum_ok_ff, tag_ff};

endmodule

>>> design/rfhx_checker.sv
// port-level checks for the rfid frame parser, bound to the top level
module rfhx_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [7:0]                        req_tdata,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [rfhx_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import rfhx_pkg::*;

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("outputs not idle after reset");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:TAG_W+1] == '0)
      else $error("rsp padding bits not zero");

   // a waiting request beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("req beat changed while stalled");

   // with the result side taking beats, intake never blocks
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      rsp_tready && $past(rsp_tready) && $past(rsp_tready, 2) && !$past(reset)
         && !$past(reset, 2) |-> req_tready)
      else $error("intake blocked while results drain");

endmodule

bind rfid_ascii_hex_frame_parser rfhx_checker u_rfhx_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
